// ===== hdl/drg_pkg.sv =====
`default_nettype none
package drg_pkg;

  localparam int STATE_WORDS = 624;
  localparam int MT_SHIFT_M  = 397;

  localparam logic [31:0] MT_MATRIX_A = 32'h9908_B0DF;
  localparam logic [31:0] MT_TEMPER_B = 32'h9D2C_5680;
  localparam logic [31:0] MT_TEMPER_C = 32'hEFC6_0000;
  localparam logic [31:0] MT_INIT_F   = 32'd1812433253;
  localparam logic [31:0] LCG_MUL     = 32'd1103515245;
  localparam logic [31:0] LCG_ADD     = 32'd12345;
  localparam logic [31:0] LCG_MASK    = 32'h7FFF_FFFF;

  localparam int DATA_W  = 32;
  localparam int PADDR_W = 3;

  localparam logic REG_ALGO_SELECT = 1'b0;

  localparam logic REQ_DRAW = 1'b0;
  localparam logic REQ_SEED = 1'b1;

  localparam logic ALGO_LCG = 1'b0;
  localparam logic ALGO_MT  = 1'b1;

  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_NOSEED = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LCG_MUL,
    ST_LCG_ADD,
    ST_FILL_MUL,
    ST_FILL_ADD,
    ST_TW_START,
    ST_TW_READ,
    ST_TW_WRITE,
    ST_MT_READ,
    ST_MT_TEMPER,
    ST_RESP
  } drg_state_t;

  function automatic logic [31:0] mt_temper(input logic [31:0] y_in);
    logic [31:0] y;
    y = y_in;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & MT_TEMPER_B);
    y = y ^ ((y << 15) & MT_TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/drg_ram.sv =====
`default_nettype none
module drg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 624
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic      [WIDTH-1:0]         rdata_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

// ===== hdl/dual_mode_random_generator.sv =====
// Random number generator with two modes: 31-bit linear congruential or MT19937.
// Input channel s_*: s_tuser is the request kind (0 draw, 1 seed), s_tdata the
// seed. Output channel m_*: m_tdata is the drawn value (or the echoed seed),
// m_tuser the status (1 = MT draw before any MT seed, value 0).
// APB register 0 (address 0): algo_select, 0 LCG, 1 MT19937. Write it only
// while the block is idle.
// One request is in flight at a time; s_tready is high only when idle.
// One 32x32 multiplier and one two-read RAM; steps from accept to result:
//   LCG draw: multiply, then add and mask; MT draw: table read, then temper.
//   MT seed: write word 0, then multiply and add per word; the first MT draw
//   after it and every 624th draw after that first run the twist (read, write).
// The result waits in an output register; a new request can be accepted while
// it waits, and the next result holds until m_tready takes the previous word.
// Reset selects LCG mode, clears the LCG state to zero and marks MT unseeded;
// the table itself is not cleared and is filled by the first MT seed.
`default_nettype none
module dual_mode_random_generator #(
  parameter int STATE_WORDS = drg_pkg::STATE_WORDS
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [31:0]                 s_tdata,  // seed_value
  input  wire logic                        s_tuser,  // req_type
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic      [31:0]                 m_tdata,  // random_value
  output logic                             m_tuser,  // status
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [drg_pkg::PADDR_W-1:0] paddr,
  input  wire logic [drg_pkg::DATA_W-1:0]  pwdata,
  output logic      [drg_pkg::DATA_W-1:0]  prdata,
  output logic                             pready
);

  localparam int AW = $clog2(STATE_WORDS);
  localparam int IW = $clog2(STATE_WORDS + 2);
  localparam logic [AW-1:0] LAST_K   = AW'(STATE_WORDS - 1);
  localparam logic [IW-1:0] IDX_FULL = IW'(STATE_WORDS);
  localparam logic [IW-1:0] IDX_NONE = IW'(STATE_WORDS + 1);
  localparam logic [AW:0]   FAR_OFF  = (AW+1)'(drg_pkg::MT_SHIFT_M);
  localparam logic [AW:0]   WRAP     = (AW+1)'(STATE_WORDS);

  drg_pkg::drg_state_t state, state_next;

  logic          algo_select;
  logic [31:0]   lcg_state;
  logic [IW-1:0] mt_index;
  logic [AW-1:0] k;
  logic [31:0]   prev;
  logic [31:0]   cur;
  logic [31:0]   prod;
  logic [31:0]   res_value;
  logic          res_status;

  logic          s_fire;
  logic          out_free;
  logic          cfg_wr;

  logic [31:0]   mul_a;
  logic [31:0]   mul_b;
  logic [31:0]   mul_out;
  logic [31:0]   fill_word;
  logic [31:0]   tw_y;
  logic [31:0]   tw_word;
  logic [AW-1:0] k_nxt;
  logic [AW:0]   far_sum;
  logic [AW-1:0] k_far;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic [AW-1:0] ram_raddr_a;
  logic [AW-1:0] ram_raddr_b;
  logic [31:0]   ram_rdata_a;
  logic [31:0]   ram_rdata_b;

  assign s_tready = (state == drg_pkg::ST_IDLE);
  assign s_fire   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[drg_pkg::PADDR_W-1] == drg_pkg::REG_ALGO_SELECT);
  assign prdata = (paddr[drg_pkg::PADDR_W-1] == drg_pkg::REG_ALGO_SELECT) ?
                  {{(drg_pkg::DATA_W-1){1'b0}}, algo_select} : '0;

  // shared multiplier: LCG step or seed-fill recurrence
  assign mul_a   = (state == drg_pkg::ST_LCG_MUL) ? lcg_state : (prev ^ (prev >> 30));
  assign mul_b   = (state == drg_pkg::ST_LCG_MUL) ? drg_pkg::LCG_MUL : drg_pkg::MT_INIT_F;
  assign mul_out = mul_a * mul_b;

  assign fill_word = prod + {{(32-AW){1'b0}}, k};

  assign k_nxt   = (k == LAST_K) ? '0 : k + AW'(1);
  assign far_sum = {1'b0, k} + FAR_OFF;
  assign k_far   = (far_sum >= WRAP) ? AW'(far_sum - WRAP) : far_sum[AW-1:0];

  assign tw_y    = {cur[31], ram_rdata_a[30:0]};
  assign tw_word = ram_rdata_b ^ (tw_y >> 1) ^ (tw_y[0] ? drg_pkg::MT_MATRIX_A : 32'd0);

  always_comb begin
    state_next = state;
    unique case (state)
      drg_pkg::ST_IDLE: begin
        if (s_fire) begin
          if (s_tuser == drg_pkg::REQ_SEED) begin
            state_next = (algo_select == drg_pkg::ALGO_MT) ? drg_pkg::ST_FILL_MUL
                                                           : drg_pkg::ST_RESP;
          end else if (algo_select == drg_pkg::ALGO_LCG) begin
            state_next = drg_pkg::ST_LCG_MUL;
          end else if (mt_index > IDX_FULL) begin
            state_next = drg_pkg::ST_RESP;
          end else if (mt_index == IDX_FULL) begin
            state_next = drg_pkg::ST_TW_START;
          end else begin
            state_next = drg_pkg::ST_MT_READ;
          end
        end
      end
      drg_pkg::ST_LCG_MUL:   state_next = drg_pkg::ST_LCG_ADD;
      drg_pkg::ST_LCG_ADD:   state_next = drg_pkg::ST_RESP;
      drg_pkg::ST_FILL_MUL:  state_next = drg_pkg::ST_FILL_ADD;
      drg_pkg::ST_FILL_ADD: begin
        state_next = (k == LAST_K) ? drg_pkg::ST_RESP : drg_pkg::ST_FILL_MUL;
      end
      drg_pkg::ST_TW_START:  state_next = drg_pkg::ST_TW_READ;
      drg_pkg::ST_TW_READ:   state_next = drg_pkg::ST_TW_WRITE;
      drg_pkg::ST_TW_WRITE: begin
        state_next = (k == LAST_K) ? drg_pkg::ST_MT_READ : drg_pkg::ST_TW_READ;
      end
      drg_pkg::ST_MT_READ:   state_next = drg_pkg::ST_MT_TEMPER;
      drg_pkg::ST_MT_TEMPER: state_next = drg_pkg::ST_RESP;
      drg_pkg::ST_RESP: begin
        if (out_free) begin
          state_next = drg_pkg::ST_IDLE;
        end
      end
      default:               state_next = drg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = k;
    ram_wdata   = fill_word;
    ram_raddr_a = k_nxt;
    ram_raddr_b = k_far;
    unique case (state)
      drg_pkg::ST_IDLE: begin
        ram_we    = s_fire && (s_tuser == drg_pkg::REQ_SEED) &&
                    (algo_select == drg_pkg::ALGO_MT);
        ram_waddr = '0;
        ram_wdata = s_tdata;
      end
      drg_pkg::ST_FILL_ADD: begin
        ram_we = 1'b1;
      end
      drg_pkg::ST_TW_START: begin
        ram_raddr_a = '0;
      end
      drg_pkg::ST_TW_WRITE: begin
        ram_we    = 1'b1;
        ram_wdata = tw_word;
      end
      drg_pkg::ST_MT_READ: begin
        ram_raddr_a = mt_index[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= drg_pkg::ST_IDLE;
      algo_select <= drg_pkg::ALGO_LCG;
      lcg_state   <= '0;
      mt_index    <= IDX_NONE;
      m_tvalid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr) begin
        algo_select <= pwdata[0];
      end
      if (state == drg_pkg::ST_RESP && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        drg_pkg::ST_IDLE: begin
          if (s_fire) begin
            if (s_tuser == drg_pkg::REQ_SEED) begin
              lcg_state <= s_tdata;
            end
          end
        end
        drg_pkg::ST_LCG_ADD: begin
          lcg_state <= (prod + drg_pkg::LCG_ADD) & drg_pkg::LCG_MASK;
        end
        drg_pkg::ST_FILL_ADD: begin
          if (k == LAST_K) begin
            mt_index <= IDX_FULL;
          end
        end
        drg_pkg::ST_TW_WRITE: begin
          if (k == LAST_K) begin
            mt_index <= '0;
          end
        end
        drg_pkg::ST_MT_TEMPER: begin
          mt_index <= mt_index + IW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      drg_pkg::ST_IDLE: begin
        k    <= AW'(1);
        prev <= s_tdata;
        if (s_tuser == drg_pkg::REQ_SEED) begin
          res_value  <= s_tdata;
          res_status <= drg_pkg::STATUS_OK;
        end else if (algo_select == drg_pkg::ALGO_MT && mt_index > IDX_FULL) begin
          res_value  <= '0;
          res_status <= drg_pkg::STATUS_NOSEED;
        end else begin
          res_value  <= '0;
          res_status <= drg_pkg::STATUS_OK;
        end
      end
      drg_pkg::ST_LCG_MUL: begin
        prod <= mul_out;
      end
      drg_pkg::ST_LCG_ADD: begin
        res_value <= (prod + drg_pkg::LCG_ADD) & drg_pkg::LCG_MASK;
      end
      drg_pkg::ST_FILL_MUL: begin
        prod <= mul_out;
      end
      drg_pkg::ST_FILL_ADD: begin
        prev <= fill_word;
        k    <= k + AW'(1);
      end
      drg_pkg::ST_TW_START: begin
        k <= '0;
      end
      drg_pkg::ST_TW_READ: begin
        if (k == '0) begin
          cur <= ram_rdata_a;
        end
      end
      drg_pkg::ST_TW_WRITE: begin
        cur <= ram_rdata_a;
        k   <= k_nxt;
      end
      drg_pkg::ST_MT_TEMPER: begin
        res_value <= drg_pkg::mt_temper(ram_rdata_a);
      end
      drg_pkg::ST_RESP: begin
        if (out_free) begin
          m_tdata <= res_value;
          m_tuser <= res_status;
        end
      end
      default: begin
      end
    endcase
  end

  drg_ram #(
    .WIDTH (32),
    .DEPTH (STATE_WORDS)
  ) u_table (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .rdata_a (ram_rdata_a),
    .raddr_b (ram_raddr_b),
    .rdata_b (ram_rdata_b)
  );

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    mt_index <= IDX_NONE)
    else $error("mt_index out of range");

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == drg_pkg::ST_IDLE || state == drg_pkg::ST_FILL_ADD ||
                state == drg_pkg::ST_TW_WRITE))
    else $error("table written outside seed or twist");

  a_twist_done: assert property (@(posedge clk) disable iff (rst)
    (state == drg_pkg::ST_TW_WRITE && k == LAST_K) |=>
      (mt_index == '0 && state == drg_pkg::ST_MT_READ))
    else $error("twist did not hand over to the read");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == drg_pkg::STATUS_NOSEED) |-> (m_tdata == '0))
    else $error("error word carries a value");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    (state == drg_pkg::ST_FILL_ADD || state == drg_pkg::ST_TW_WRITE) |-> !s_tready)
    else $error("ready during table walk");

endmodule
`default_nettype wire

// ===== verif/tb_dual_mode_random_generator.sv =====
`timescale 1ns / 100ps
module tb_dual_mode_random_generator;

  localparam logic [31:0] MT_TOP_BIT = ~drg_pkg::LCG_MASK;
  localparam int N_SCRIPT = 24;
  localparam int N_PHASES = 6;

  localparam logic LCG    = drg_pkg::ALGO_LCG;
  localparam logic MT     = drg_pkg::ALGO_MT;
  localparam logic DRAW   = drg_pkg::REQ_DRAW;
  localparam logic SEED   = drg_pkg::REQ_SEED;
  localparam logic OK     = drg_pkg::STATUS_OK;
  localparam logic NOSEED = drg_pkg::STATUS_NOSEED;

  typedef struct packed {
    logic [31:0] value;
    logic        status;
  } rng_word_t;

  typedef struct packed {
    logic        algo;
    logic        req;
    logic [31:0] seed;
    logic        typed;
    logic [31:0] want_value;
    logic        want_status;
  } script_row_t;

  typedef struct packed {
    logic        algo;
    int unsigned count;
    int unsigned seed_pct;
    logic        first_seed;
    logic        quiet;
  } phase_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [31:0] s_tdata  = 32'h0;
  logic        s_tuser  = DRAW;
  logic        m_tready = 1'b0;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [drg_pkg::PADDR_W-1:0] paddr  = '0;
  logic [drg_pkg::DATA_W-1:0]  pwdata = '0;

  logic                        s_tready;
  logic                        m_tvalid;
  logic [31:0]                 m_tdata;
  logic                        m_tuser;
  logic [drg_pkg::DATA_W-1:0]  prdata;
  logic                        pready;

  logic [31:0] mt_tab [drg_pkg::STATE_WORDS];
  logic [9:0]  mt_pos  = 10'd625;
  logic [31:0] lcg_now = 32'h0;
  logic        algo_now = LCG;

  rng_word_t expected_words [$];
  rng_word_t head_word;
  int unsigned mismatch_count = 0;
  logic no_idle = 1'b0;

  script_row_t script [N_SCRIPT] = '{
    '{LCG, DRAW, 32'h0000_0000, 1'b1, 32'd12345,       OK},
    '{LCG, DRAW, 32'hFFFF_FFFF, 1'b0, 32'h0,           OK},
    '{MT,  DRAW, 32'h0000_0000, 1'b1, 32'h0,           NOSEED},
    '{MT,  DRAW, 32'hFFFF_FFFF, 1'b1, 32'h0,           NOSEED},
    '{LCG, SEED, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF,   OK},
    '{LCG, DRAW, 32'h0000_0000, 1'b0, 32'h0,           OK},
    '{LCG, SEED, 32'h0000_0000, 1'b1, 32'h0,           OK},
    '{LCG, DRAW, 32'h0000_0000, 1'b1, 32'd12345,       OK},
    '{MT,  DRAW, 32'h0000_0000, 1'b1, 32'h0,           NOSEED},
    '{MT,  SEED, 32'h0000_0000, 1'b1, 32'h0,           OK},
    '{MT,  DRAW, 32'hAAAA_AAAA, 1'b0, 32'h0,           OK},
    '{MT,  DRAW, 32'h5555_5555, 1'b0, 32'h0,           OK},
    '{LCG, DRAW, 32'h0000_0000, 1'b1, 32'd12345,       OK},
    '{MT,  DRAW, 32'h0000_0000, 1'b0, 32'h0,           OK},
    '{MT,  SEED, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF,   OK},
    '{MT,  DRAW, 32'h0000_0000, 1'b0, 32'h0,           OK},
    '{MT,  SEED, 32'd5489,      1'b1, 32'd5489,        OK},
    '{MT,  DRAW, 32'h0000_0000, 1'b1, 32'd3499211612,  OK},
    '{MT,  DRAW, 32'h0000_0000, 1'b1, 32'd581869302,   OK},
    '{LCG, SEED, 32'h8000_0000, 1'b1, 32'h8000_0000,   OK},
    '{LCG, DRAW, 32'h0000_0000, 1'b0, 32'h0,           OK},
    '{LCG, SEED, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF,   OK},
    '{LCG, DRAW, 32'h0000_0000, 1'b0, 32'h0,           OK},
    '{MT,  DRAW, 32'h0000_0000, 1'b0, 32'h0,           OK}
  };

  phase_t phases [N_PHASES] = '{
    '{LCG, 250, 10, 1'b0, 1'b0},
    '{MT,  500,  2, 1'b1, 1'b0},
    '{LCG, 200, 10, 1'b0, 1'b1},
    '{MT,  700,  0, 1'b1, 1'b0},
    '{LCG, 150, 10, 1'b0, 1'b0},
    '{MT,  150,  5, 1'b0, 1'b0}
  };

  dual_mode_random_generator i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= 100) begin
      $display("%0t ns: %s got %h want %h", $time, what, got, want);
    end
  endtask

  task automatic predict_word(input logic req, input logic [31:0] seed,
                              output rng_word_t w);
    logic [31:0] y;
    logic [31:0] ya;
    logic [31:0] t;
    w.value  = 32'h0;
    w.status = OK;
    if (req == SEED) begin
      lcg_now = seed;
      if (algo_now == MT) begin
        mt_tab[0] = seed;
        for (int k = 1; k < drg_pkg::STATE_WORDS; k++) begin
          mt_tab[k] = drg_pkg::MT_INIT_F * (mt_tab[k-1] ^ (mt_tab[k-1] >> 30)) + 32'(k);
        end
        mt_pos = 10'(drg_pkg::STATE_WORDS);
      end
      w.value = seed;
    end else if (algo_now == LCG) begin
      lcg_now = (lcg_now * drg_pkg::LCG_MUL + drg_pkg::LCG_ADD) & drg_pkg::LCG_MASK;
      w.value = lcg_now;
    end else if (mt_pos > drg_pkg::STATE_WORDS) begin
      w.status = NOSEED;
    end else begin
      if (mt_pos == drg_pkg::STATE_WORDS) begin
        for (int k = 0; k < drg_pkg::STATE_WORDS; k++) begin
          y  = (mt_tab[k] & MT_TOP_BIT) |
               (mt_tab[(k + 1) % drg_pkg::STATE_WORDS] & drg_pkg::LCG_MASK);
          ya = y >> 1;
          if (y[0]) begin
            ya = ya ^ drg_pkg::MT_MATRIX_A;
          end
          mt_tab[k] = mt_tab[(k + drg_pkg::MT_SHIFT_M) % drg_pkg::STATE_WORDS] ^ ya;
        end
        mt_pos = 10'd0;
      end
      t = mt_tab[mt_pos];
      t = t ^ (t >> 11);
      t = t ^ ((t << 7) & drg_pkg::MT_TEMPER_B);
      t = t ^ ((t << 15) & drg_pkg::MT_TEMPER_C);
      t = t ^ (t >> 18);
      w.value = t;
      mt_pos = mt_pos + 10'd1;
    end
  endtask

  task automatic send_request(input logic req, input logic [31:0] seed,
                              input logic typed, input rng_word_t typed_word);
    rng_word_t w;
    while (!no_idle && $urandom_range(0, 99) < 11) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= seed;
    do @(posedge clk); while (!s_tready);
    predict_word(req, seed, w);
    expected_words.push_back(typed ? typed_word : w);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_algo(input logic val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= drg_pkg::PADDR_W'(4 * drg_pkg::REG_ALGO_SELECT);
    pwdata  <= drg_pkg::DATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    algo_now = val;
  endtask

  always @(posedge clk) begin
    m_tready <= no_idle || ($urandom_range(0, 99) >= 11);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_words.size() == 0) begin
        flag_mismatch("word with nothing expected", m_tdata, 32'h0);
      end else begin
        head_word = expected_words.pop_front();
        if (m_tdata !== head_word.value) begin
          flag_mismatch("random_value", m_tdata, head_word.value);
        end
        if (m_tuser !== head_word.status) begin
          flag_mismatch("status", {31'b0, m_tuser}, {31'b0, head_word.status});
        end
      end
    end
  end

  initial begin
    logic next_req;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int r = 0; r < N_SCRIPT; r++) begin
      if (script[r].algo != algo_now) begin
        drain_results();
        write_algo(script[r].algo);
      end
      send_request(script[r].req, script[r].seed, script[r].typed,
                   {script[r].want_value, script[r].want_status});
    end
    for (int p = 0; p < N_PHASES; p++) begin
      drain_results();
      write_algo(phases[p].algo);
      no_idle = phases[p].quiet;
      for (int n = 0; n < phases[p].count; n++) begin
        next_req = ((n == 0 && phases[p].first_seed) ||
                    $urandom_range(0, 99) < phases[p].seed_pct) ? SEED : DRAW;
        // hold off now and then until every word is back
        if ($urandom_range(0, 199) == 0) begin
          drain_results();
        end
        send_request(next_req, $urandom, 1'b0, '0);
      end
      no_idle = 1'b0;
    end
    drain_results();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/drg_pkg.sv
hdl/drg_ram.sv
hdl/dual_mode_random_generator.sv
verif/tb_dual_mode_random_generator.sv
